>>> hw/rtl/bbx_pkg.sv
// bbx_pkg: shared constants and types for the bitmap bounding box block
// no dependencies; imported by the interfaces and every rtl module
`default_nettype none

package bbx_pkg;

    localparam int CFG_W     = 13;   // configuration data width
    localparam int CFG_IDX_W = 1;    // configuration register index width
    localparam int PIX_W     = 8;    // pixels per packed byte
    localparam int EDGE_W    = 12;   // left and top edge width
    localparam int SIZE_W    = 13;   // box width and height width

    localparam int DEF_MAX_WIDTH  = 4096;
    localparam int DEF_MAX_HEIGHT = 4096;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

    typedef logic [PIX_W-1:0] pixel_byte_t;

    typedef struct packed {
        logic [EDGE_W-1:0] left_edge;
        logic [EDGE_W-1:0] top_edge;
        logic [SIZE_W-1:0] box_width;
        logic [SIZE_W-1:0] box_height;
    } box_t;

endpackage

`default_nettype wire

>>> hw/rtl/bbx_if.sv
// bbx_pixel_if and bbx_box_if: valid/ready channels of the bounding box block
// depends on bbx_pkg
`default_nettype none

interface bbx_pixel_if;
    import bbx_pkg::*;

    logic        valid;
    logic        ready;
    pixel_byte_t pixel_byte;

    modport source (output valid, output pixel_byte, input ready);
    modport sink   (input valid, input pixel_byte, output ready);
endinterface

interface bbx_box_if;
    import bbx_pkg::*;

    logic              valid;
    logic              ready;
    logic [EDGE_W-1:0] left_edge;
    logic [EDGE_W-1:0] top_edge;
    logic [SIZE_W-1:0] box_width;
    logic [SIZE_W-1:0] box_height;

    modport source (output valid, output left_edge, output top_edge,
                    output box_width, output box_height, input ready);
    modport sink   (input valid, input left_edge, input top_edge,
                    input box_width, input box_height, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bbx_pixel_scan.sv
// bbx_pixel_scan: masks padding pixels and finds first and last set column
// depends on bbx_pkg
`default_nettype none

module bbx_pixel_scan #(
    parameter int MAX_WIDTH = bbx_pkg::DEF_MAX_WIDTH
) (
    input  wire bbx_pkg::pixel_byte_t                          pixel_byte,
    input  wire [((MAX_WIDTH+7)/8 > 1 ? $clog2((MAX_WIDTH+7)/8) : 1)-1:0] byte_column,
    input  wire [$clog2(MAX_WIDTH+1)-1:0]                      width,
    output logic                                               hit,
    output logic [$clog2(MAX_WIDTH)-1:0]                       first_col,
    output logic [$clog2(MAX_WIDTH)-1:0]                       last_col
);
    import bbx_pkg::*;

    localparam int BCW  = ((MAX_WIDTH+7)/8 > 1) ? $clog2((MAX_WIDTH+7)/8) : 1;
    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH+1);
    localparam int AW   = (BCW + 3 > WW) ? BCW + 3 : WW;

    logic [AW-1:0]    base;
    logic [AW-1:0]    width_ext;
    logic [AW-1:0]    remaining;
    logic             in_row;
    logic [PIX_W-1:0] keep;      // keep[i] is pixel i from the left
    logic [2:0]       first_idx;
    logic [2:0]       last_idx;

    assign base      = AW'({byte_column, 3'b000});
    assign width_ext = AW'(width);
    assign in_row    = base < width_ext;
    assign remaining = width_ext - base;

    always_comb
    begin
        for (int i = 0; i < PIX_W; i++)
        begin
            keep[i] = in_row && (remaining > AW'(i)) && pixel_byte[PIX_W-1-i];
        end
    end

    // leftmost and rightmost kept pixel
    always_comb
    begin
        first_idx = 3'd0;
        last_idx  = 3'd0;
        for (int i = PIX_W - 1; i >= 0; i--)
        begin
            if (keep[i])
            begin
                first_idx = 3'(i);
            end
        end
        for (int i = 0; i < PIX_W; i++)
        begin
            if (keep[i])
            begin
                last_idx = 3'(i);
            end
        end
    end

    assign hit       = |keep;
    assign first_col = COLW'(base + AW'(first_idx));
    assign last_col  = COLW'(base + AW'(last_idx));

endmodule

`default_nettype wire

>>> hw/rtl/bbx_tracker.sv
// bbx_tracker: raster position counters, running box extremes, result forming
// depends on bbx_pkg
`default_nettype none

module bbx_tracker #(
    parameter int MAX_WIDTH  = bbx_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbx_pkg::DEF_MAX_HEIGHT
) (
    input  wire                                                clk,
    input  wire                                                rst_n,
    input  wire                                                step,
    input  wire                                                hit,
    input  wire [$clog2(MAX_WIDTH)-1:0]                        first_col,
    input  wire [$clog2(MAX_WIDTH)-1:0]                        last_col,
    input  wire [((MAX_WIDTH+7)/8 > 1 ? $clog2((MAX_WIDTH+7)/8) : 1):0] row_byte_count,
    input  wire [(MAX_HEIGHT > 1 ? $clog2(MAX_HEIGHT) : 1):0]  height,
    output logic [((MAX_WIDTH+7)/8 > 1 ? $clog2((MAX_WIDTH+7)/8) : 1)-1:0] byte_column,
    output logic                                               image_end,
    output bbx_pkg::box_t                                      box
);
    import bbx_pkg::*;

    localparam int BCW  = ((MAX_WIDTH+7)/8 > 1) ? $clog2((MAX_WIDTH+7)/8) : 1;
    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [BCW-1:0]  byte_column_reg, byte_column_next;
    logic [RW-1:0]   row_count_reg, row_count_next;
    logic [COLW-1:0] min_col_reg, min_col_next;
    logic [COLW-1:0] max_col_reg, max_col_next;
    logic [RW-1:0]   min_row_reg, min_row_next;
    logic [RW-1:0]   max_row_reg, max_row_next;
    logic            any_seen_reg, any_seen_next;
    logic            row_end;
    logic [COLW:0]   span_w;
    logic [RW:0]     span_h;

    assign row_end   = ({1'b0, byte_column_reg} + 1'b1) >= row_byte_count;
    assign image_end = row_end && (({1'b0, row_count_reg} + 1'b1) >= height);

    // extremes including the byte being processed
    always_comb
    begin
        min_col_next  = min_col_reg;
        max_col_next  = max_col_reg;
        min_row_next  = min_row_reg;
        max_row_next  = max_row_reg;
        any_seen_next = any_seen_reg | hit;
        if (hit)
        begin
            if (first_col < min_col_reg)
            begin
                min_col_next = first_col;
            end
            if (last_col > max_col_reg)
            begin
                max_col_next = last_col;
            end
            if (row_count_reg < min_row_reg)
            begin
                min_row_next = row_count_reg;
            end
            if (row_count_reg > max_row_reg)
            begin
                max_row_next = row_count_reg;
            end
        end
    end

    assign span_w = {1'b0, max_col_next} - {1'b0, min_col_next} + 1'b1;
    assign span_h = {1'b0, max_row_next} - {1'b0, min_row_next} + 1'b1;

    always_comb
    begin
        if (any_seen_next)
        begin
            box.left_edge  = EDGE_W'(min_col_next);
            box.top_edge   = EDGE_W'(min_row_next);
            box.box_width  = SIZE_W'(span_w);
            box.box_height = SIZE_W'(span_h);
        end
        else
        begin
            box.left_edge  = '0;
            box.top_edge   = '0;
            box.box_width  = SIZE_W'(1);
            box.box_height = SIZE_W'(1);
        end
    end

    always_comb
    begin
        byte_column_next = byte_column_reg + 1'b1;
        row_count_next   = row_count_reg;
        if (row_end)
        begin
            byte_column_next = '0;
            row_count_next   = row_count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_column_reg <= '0;
            row_count_reg   <= '0;
            min_col_reg     <= '1;
            max_col_reg     <= '0;
            min_row_reg     <= '1;
            max_row_reg     <= '0;
            any_seen_reg    <= 1'b0;
        end
        else if (step)
        begin
            if (image_end)
            begin
                byte_column_reg <= '0;
                row_count_reg   <= '0;
                min_col_reg     <= '1;
                max_col_reg     <= '0;
                min_row_reg     <= '1;
                max_row_reg     <= '0;
                any_seen_reg    <= 1'b0;
            end
            else
            begin
                byte_column_reg <= byte_column_next;
                row_count_reg   <= row_count_next;
                min_col_reg     <= min_col_next;
                max_col_reg     <= max_col_next;
                min_row_reg     <= min_row_next;
                max_row_reg     <= max_row_next;
                any_seen_reg    <= any_seen_next;
            end
        end
    end

    assign byte_column = byte_column_reg;

endmodule

`default_nettype wire

>>> hw/rtl/bitmap_bounding_box.sv
// bitmap_bounding_box: top level of the packed 1-bit image bounding box block
// depends on bbx_pkg, bbx_if, bbx_pixel_scan and bbx_tracker
//
// pixel_in: one request per packed byte in raster order, bit 7 leftmost, rows
//   padded to whole bytes; padding bits past the configured width are ignored
// box_out: one request after the last byte of the last row with left edge,
//   top edge, width and height of the set pixels; an image with no set pixel
//   reports left 0, top 0, width 1, height 1
// image_width and image_height are to be written by the user through cfg_write_en,
//   cfg_index and cfg_data only while the block is idle, which the block itself does
//   not enforce; 0 counts as 1 and values above the maximum count as the maximum
// a byte is taken into the input register and folded into the running box when
//   it leaves that register; the last byte of an image loads the result register
//   as it leaves, which sets box valid
// throughput: one byte per cycle unless a closing byte waits for a full result
//   register, set by the combinational compare and registered update of the extremes
// reset clears the counters and the box, empties both registers and sets
//   both sizes to 1
// while box_out is stalled the block keeps taking bytes; only the last byte of
//   the next image waits in the input register until the result register is free
`default_nettype none

module bitmap_bounding_box #(
    parameter int MAX_WIDTH  = bbx_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbx_pkg::DEF_MAX_HEIGHT
) (
    input  wire                            clk,
    input  wire                            rst_n,
    bbx_pixel_if.sink                      pixel_in,
    bbx_box_if.source                      box_out,
    input  wire                            cfg_write_en,
    input  wire [bbx_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [bbx_pkg::CFG_W-1:0]       cfg_data
);
    import bbx_pkg::*;

    localparam int BCW  = ((MAX_WIDTH+7)/8 > 1) ? $clog2((MAX_WIDTH+7)/8) : 1;
    localparam int COLW = $clog2(MAX_WIDTH);
    localparam int WW   = $clog2(MAX_WIDTH+1);
    localparam int RW   = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    // compare widths for clamping the size registers
    localparam int CWW  = (WW > CFG_W) ? WW : CFG_W;
    localparam int HW0  = $clog2(MAX_HEIGHT+1);
    localparam int CHW  = (HW0 > CFG_W) ? HW0 : CFG_W;

    // configuration registers
    logic [CFG_W-1:0] image_width_reg;
    logic [CFG_W-1:0] image_height_reg;

    // input register
    logic        s1_valid_reg, s1_valid_next;
    pixel_byte_t pixel_byte_reg;

    // result register
    logic        out_valid_reg, out_valid_next;
    box_t        box_reg;

    logic           in_fire;
    logic           advance;
    logic [CWW-1:0] width_cmp;
    logic [CHW-1:0] height_cmp;
    logic [WW-1:0]  width_eff;
    logic [RW:0]    height_eff;
    logic [WW:0]    width_plus;
    logic [BCW:0]   row_byte_count;
    logic [BCW-1:0] byte_column;
    logic           hit;
    logic [COLW-1:0] first_col;
    logic [COLW-1:0] last_col;
    logic           image_end;
    box_t           box_now;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= CFG_W'(1);
            image_height_reg <= CFG_W'(1);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp sizes into 1..maximum
    always_comb
    begin
        width_cmp  = CWW'(image_width_reg);
        height_cmp = CHW'(image_height_reg);
        if (width_cmp == '0)
        begin
            width_eff = WW'(1);
        end
        else if (width_cmp > CWW'(MAX_WIDTH))
        begin
            width_eff = WW'(MAX_WIDTH);
        end
        else
        begin
            width_eff = WW'(width_cmp);
        end
        if (height_cmp == '0)
        begin
            height_eff = (RW+1)'(1);
        end
        else if (height_cmp > CHW'(MAX_HEIGHT))
        begin
            height_eff = (RW+1)'(MAX_HEIGHT);
        end
        else
        begin
            height_eff = (RW+1)'(height_cmp);
        end
    end

    // bytes per row, rounding up
    assign width_plus     = {1'b0, width_eff} + (WW+1)'(7);
    assign row_byte_count = (BCW+1)'(width_plus >> 3);

    bbx_pixel_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .pixel_byte  (pixel_byte_reg),
        .byte_column (byte_column),
        .width       (width_eff),
        .hit         (hit),
        .first_col   (first_col),
        .last_col    (last_col)
    );

    // the held byte moves on unless it closes an image and the result
    // register is still full
    assign advance = s1_valid_reg && (!image_end || !out_valid_reg || box_out.ready);

    bbx_tracker #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_tracker (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (advance),
        .hit            (hit),
        .first_col      (first_col),
        .last_col       (last_col),
        .row_byte_count (row_byte_count),
        .height         (height_eff),
        .byte_column    (byte_column),
        .image_end      (image_end),
        .box            (box_now)
    );

    // input register: free when empty or draining this cycle
    assign pixel_in.ready = !s1_valid_reg || advance;
    assign in_fire        = pixel_in.valid && pixel_in.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_fire)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && image_end)
        begin
            out_valid_next = 1'b1;
        end
        else if (box_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pixel_byte_reg <= pixel_in.pixel_byte;
        end
        if (advance && image_end)
        begin
            box_reg <= box_now;
        end
    end

    assign box_out.valid      = out_valid_reg;
    assign box_out.left_edge  = box_reg.left_edge;
    assign box_out.top_edge   = box_reg.top_edge;
    assign box_out.box_width  = box_reg.box_width;
    assign box_out.box_height = box_reg.box_height;

`ifndef SYNTHESIS
    // an accepted byte is always held in the input register next cycle
    a_fire_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> s1_valid_reg)
        else $error("accepted byte not held in input register");

    // a closing byte never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !box_out.ready && advance) |-> !image_end)
        else $error("pending result overwritten");

    // closing an image always presents a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && image_end) |=> out_valid_reg)
        else $error("image closed without a result");

    // a full input register with a free result register always drains
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_valid_reg) |-> advance)
        else $error("input register stuck while output free");
`endif

endmodule

`default_nettype wire

>>> tb/bbx_box_checker.sv
// bbx_box_checker: predicts the bounding box of each streamed image and checks box_out
// watches pixel_in, box_out and the register write port; depends on bbx_pkg and bbx_if
`default_nettype none

module bbx_box_checker #(
    parameter int MAX_WIDTH  = bbx_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bbx_pkg::DEF_MAX_HEIGHT
) (
    input  wire                          clk,
    input  wire                          rst_n,
    bbx_pixel_if                         pixel_in,
    bbx_box_if                           box_out,
    input  wire                          cfg_write_en,
    input  wire [bbx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire [bbx_pkg::CFG_W-1:0]     cfg_data,
    output int                           boxes_due,
    output int                           mismatches
);
    import bbx_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    int unsigned      byte_col;
    int unsigned      row_idx;
    int unsigned      min_col;
    int unsigned      max_col;
    int unsigned      min_row;
    int unsigned      max_row;
    bit               pixel_seen;
    box_t             expected_boxes[$];
    int               fail_total = 0;

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    task automatic clear_box();
        byte_col   = 0;
        row_idx    = 0;
        min_col    = 32'hFFFF_FFFF;
        max_col    = 0;
        min_row    = 32'hFFFF_FFFF;
        max_row    = 0;
        pixel_seen = 1'b0;
    endtask

    // fold one byte into the running box; queue the box when the image ends
    task automatic absorb_pixel_byte(input pixel_byte_t raw);
        int unsigned w;
        int unsigned h;
        int unsigned row_bytes;
        int unsigned base_col;
        int unsigned first_set;
        int unsigned last_set;
        logic [7:0]  mask;
        logic [7:0]  bits;
        box_t        box;
        w         = clamp_dim(width_reg, MAX_WIDTH);
        h         = clamp_dim(height_reg, MAX_HEIGHT);
        row_bytes = (w + 7) >> 3;
        base_col  = byte_col * 8;
        mask      = 8'h00;
        if (base_col < w)
        begin
            if (w - base_col >= 8)
                mask = 8'hFF;
            else
                mask = 8'hFF << (8 - (w - base_col));
        end
        bits = raw & mask;
        if (bits != 8'h00)
        begin
            first_set = 0;
            while (!bits[7 - first_set])
                first_set++;
            last_set = 7;
            while (!bits[7 - last_set])
                last_set--;
            if (base_col + first_set < min_col)
                min_col = base_col + first_set;
            if (base_col + last_set > max_col)
                max_col = base_col + last_set;
            if (row_idx < min_row)
                min_row = row_idx;
            if (row_idx > max_row)
                max_row = row_idx;
            pixel_seen = 1'b1;
        end
        if (byte_col + 1 >= row_bytes)
        begin
            byte_col = 0;
            if (row_idx + 1 >= h)
            begin
                box.left_edge  = '0;
                box.top_edge   = '0;
                box.box_width  = SIZE_W'(1);
                box.box_height = SIZE_W'(1);
                if (pixel_seen)
                begin
                    box.left_edge  = min_col[EDGE_W-1:0];
                    box.top_edge   = min_row[EDGE_W-1:0];
                    box.box_width  = SIZE_W'(max_col - min_col + 1);
                    box.box_height = SIZE_W'(max_row - min_row + 1);
                end
                expected_boxes.push_back(box);
                clear_box();
            end
            else
                row_idx++;
        end
        else
            byte_col++;
    endtask

    task automatic check_box();
        box_t want;
        if (expected_boxes.size() == 0)
        begin
            fail_total++;
            if (fail_total <= REPORT_LIMIT)
                $display("unexpected box: left %0d top %0d width %0d height %0d",
                         box_out.left_edge, box_out.top_edge,
                         box_out.box_width, box_out.box_height);
        end
        else
        begin
            want = expected_boxes.pop_front();
            if (box_out.left_edge !== want.left_edge || box_out.top_edge !== want.top_edge ||
                box_out.box_width !== want.box_width || box_out.box_height !== want.box_height)
            begin
                fail_total++;
                if (fail_total <= REPORT_LIMIT)
                    $display("box mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.left_edge, want.top_edge, want.box_width, want.box_height,
                             box_out.left_edge, box_out.top_edge,
                             box_out.box_width, box_out.box_height);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  = 1;
            height_reg = 1;
            clear_box();
            expected_boxes.delete();
            boxes_due  <= 0;
            mismatches <= fail_total;
        end
        else
        begin
            if (cfg_write_en)
            begin
                if (cfg_index == REG_IMAGE_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = cfg_data;
            end
            if (box_out.valid && box_out.ready)
                check_box();
            if (pixel_in.valid && pixel_in.ready)
                absorb_pixel_byte(pixel_in.pixel_byte);
            boxes_due  <= expected_boxes.size();
            mismatches <= fail_total;
        end
    end

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// tb_top: stimulus and verdict for bitmap_bounding_box
// depends on bbx_pkg, bbx_if, the block itself and bbx_box_checker
`default_nettype none

module tb_top;
    import bbx_pkg::*;

    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 12;
    localparam int SETTLE_CYCLES   = 6;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PHASE_COUNT     = 9;
    localparam int PHASE_BYTES     = 30;
    localparam int HOLD_PHASE      = 4;
    localparam int SIZE_OVER_MAX   = 8191;  // largest value the 13-bit registers hold

    // picture content styles for one image
    typedef enum int {FILL_EMPTY, FILL_FULL, FILL_SPARSE, FILL_NOISE} fill_t;

    logic                 clk   = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    int                   boxes_due;
    int                   mismatches;

    // idling knobs shared between the stimulus and the box receiver
    int                   sender_idle_pct    = 0;
    int                   receiver_stall_pct = 0;
    bit                   hold_off_req       = 1'b0;

    // effective image geometry after clamping, as last written
    int                   row_bytes  = 1;
    int                   image_rows = 1;

    int                   idle_cycles = 0;

    bbx_pixel_if pix_if ();
    bbx_box_if   box_if ();

    bitmap_bounding_box i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_in     (pix_if),
        .box_out      (box_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    bbx_box_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_in     (pix_if),
        .box_out      (box_if),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .boxes_due    (boxes_due),
        .mismatches   (mismatches)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // watchdog: any request on either channel counts as progress
    always @(posedge clk)
    begin
        if ((pix_if.valid && pix_if.ready) || (box_if.valid && box_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    // box receiver: random stalls, plus one long hold-off on request so the
    // block backs up and stops taking pixel bytes
    initial
    begin
        box_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                box_if.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
                box_if.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic int eff_dim(input int v, input int top);
        if (v < 1)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    function automatic pixel_byte_t make_byte(input fill_t fill);
        case (fill)
            FILL_EMPTY:  return 8'h00;
            FILL_FULL:   return 8'hFF;
            FILL_SPARSE: return ($urandom_range(7) == 0) ? (8'h80 >> $urandom_range(7)) : 8'h00;
            default:     return pixel_byte_t'($urandom_range(255));
        endcase
    endfunction

    // one pixel request, with random idle cycles ahead of it; returns on acceptance
    task automatic offer_byte(input pixel_byte_t b);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pix_if.valid <= 1'b0;
            @(posedge clk);
        end
        pix_if.valid      <= 1'b1;
        pix_if.pixel_byte <= b;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
    endtask

    // stop offering, let every queued box come out, then give the pipe time to empty
    task automatic drain();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (boxes_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= CFG_W'(value);
        @(posedge clk);
        cfg_write_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_size(input int w_raw, input int h_raw);
        write_reg(REG_IMAGE_WIDTH, w_raw);
        write_reg(REG_IMAGE_HEIGHT, h_raw);
        row_bytes  = (eff_dim(w_raw, DEF_MAX_WIDTH) + 7) / 8;
        image_rows = eff_dim(h_raw, DEF_MAX_HEIGHT);
    endtask

    task automatic send_image(input fill_t fill);
        for (int r = 0; r < image_rows; r++)
            for (int c = 0; c < row_bytes; c++)
                offer_byte(make_byte(fill));
    endtask

    initial
    begin : stimulus
        int          p;
        int          n;
        int          pick;
        int          w_raw;
        int          h_raw;
        fill_t       fill;
        pixel_byte_t b;

        pix_if.valid      <= 1'b0;
        pix_if.pixel_byte <= '0;
        cfg_write_en      <= 1'b0;
        cfg_index         <= REG_IMAGE_WIDTH;
        cfg_data          <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset sizes are one by one, so each byte is a whole image;
        // bits below bit 7 are padding and must not count
        offer_byte(8'h00);
        offer_byte(8'h7F);
        offer_byte(8'h80);
        offer_byte(8'hFF);

        // zero sizes behave as one
        drain();
        set_size(0, 0);
        offer_byte(8'h80);
        offer_byte(8'h01);

        // 12 pixels wide: second byte carries four padding bits
        drain();
        set_size(12, 2);
        offer_byte(8'h00);
        offer_byte(8'h0F);
        offer_byte(8'h01);
        offer_byte(8'h80);

        // box spanning both ends of a row
        drain();
        set_size(16, 3);
        offer_byte(8'h00);
        offer_byte(8'h01);
        offer_byte(8'h80);
        offer_byte(8'h00);
        offer_byte(8'h00);
        offer_byte(8'h00);

        // sizes shrunk part way through an image: the byte now past the
        // width is dropped and ends its row, then the row count already
        // reached ends the image
        drain();
        set_size(16, 3);
        offer_byte(8'h40);
        offer_byte(8'h00);
        offer_byte(8'h20);
        drain();
        write_reg(REG_IMAGE_WIDTH, 8);
        offer_byte(8'hFF);
        drain();
        write_reg(REG_IMAGE_HEIGHT, 2);
        offer_byte(8'h10);

        // random images in phases of differing idling
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            drain();
            case (p % 4)
                0:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct    = 46;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 46;
                end
                default:
                begin
                    sender_idle_pct    = 9;
                    receiver_stall_pct = 9;
                end
            endcase
            if (p == HOLD_PHASE)
            begin
                // one-byte images make every request a box, so the block
                // stalls quickly while the receiver holds off
                set_size($urandom_range(1, 8), 1);
                hold_off_req = 1'b1;
            end
            else
            begin
                pick  = $urandom_range(9);
                w_raw = (pick == 0) ? 0 :
                        (pick == 1) ? $urandom_range(41, 200) : $urandom_range(1, 40);
                h_raw = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
                set_size(w_raw, h_raw);
            end
            n = 0;
            while (n < PHASE_BYTES)
            begin
                pick = $urandom_range(9);
                fill = (pick == 0) ? FILL_EMPTY :
                       (pick == 1) ? FILL_FULL  :
                       (pick < 5)  ? FILL_SPARSE : FILL_NOISE;
                send_image(fill);
                n += row_bytes * image_rows;
            end
        end

        // width above the maximum clamps to it; box spans the full width
        drain();
        sender_idle_pct    = 9;
        receiver_stall_pct = 9;
        set_size(SIZE_OVER_MAX, 1);
        for (int c = 0; c < row_bytes; c++)
        begin
            if (c == 0)
                b = 8'h80 | pixel_byte_t'($urandom_range(255));
            else if (c == row_bytes - 1)
                b = 8'h01 | pixel_byte_t'($urandom_range(255));
            else
                b = make_byte(FILL_SPARSE);
            offer_byte(b);
        end

        drain();
        if (mismatches == 0 && boxes_due == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
hw/rtl/bbx_pkg.sv
hw/rtl/bbx_if.sv
hw/rtl/bbx_pixel_scan.sv
hw/rtl/bbx_tracker.sv
hw/rtl/bitmap_bounding_box.sv
tb/bbx_box_checker.sv
tb/tb_top.sv
